// ===== rtl/core/mexp_pkg.sv =====
package mexp_pkg;

    localparam int MEXP_W  = 64;   // input operand width
    localparam int MEXP_RW = 63;   // residue width, modulus is below 2^63

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_INVALID = 1'b1;

    // request to the shared modular product unit
    typedef struct packed {
        logic               start;
        logic [MEXP_RW-1:0] x;      // multiplicand, below m
        logic [MEXP_W-1:0]  y;      // multiplier, scanned LSB first
        logic [MEXP_RW-1:0] m;      // modulus
    } t_mm_req;

    typedef struct packed {
        logic               done;
        logic [MEXP_RW-1:0] result;
    } t_mm_rsp;

endpackage

// ===== rtl/core/mexp_mulmod.sv =====
module mexp_mulmod (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mexp_pkg::t_mm_req i_req,
    output mexp_pkg::t_mm_rsp o_rsp
);
    import mexp_pkg::*;

    logic               r_busy;
    logic [MEXP_RW-1:0] r_acc;
    logic [MEXP_RW-1:0] r_add;
    logic [MEXP_W-1:0]  r_y;
    logic [MEXP_RW-1:0] r_m;

    logic [MEXP_W-1:0]  acc_sum;
    logic [MEXP_W-1:0]  add_dbl;
    logic [MEXP_W-1:0]  m_ext;
    logic [MEXP_RW-1:0] n_acc;
    logic [MEXP_RW-1:0] n_add;

    // one shift-add reduction step per cycle
    always_comb begin
        m_ext   = {1'b0, r_m};
        acc_sum = {1'b0, r_acc} + {1'b0, r_add};
        add_dbl = {r_add, 1'b0};
        if (r_y[0]) begin
            n_acc = (acc_sum >= m_ext) ? MEXP_RW'(acc_sum - m_ext) : acc_sum[MEXP_RW-1:0];
        end else begin
            n_acc = r_acc;
        end
        n_add = (add_dbl >= m_ext) ? MEXP_RW'(add_dbl - m_ext) : add_dbl[MEXP_RW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_y == '0) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_acc <= '0;
            r_add <= i_req.x;
            r_y   <= i_req.y;
            r_m   <= i_req.m;
        end else if (r_busy && r_y != '0) begin
            r_acc <= n_acc;
            r_add <= n_add;
            r_y   <= r_y >> 1;
        end
    end

    // a start in the done cycle restarts the unit; the sequencer chains on this
    assign o_rsp.done   = r_busy && (r_y == '0);
    assign o_rsp.result = r_acc;

endmodule

// ===== rtl/core/modular_exponentiation.sv =====
// Modular exponentiation: base ** exponent mod modulus, 64-bit signed operands.
// Input channel (i_in_valid / o_in_ready) carries base, exponent and modulus;
// one transaction is taken only while the block is idle. Output channel
// (o_out_valid / i_out_ready) carries a 63-bit result and a status bit
// (0 valid, 1 invalid: modulus zero or negative, or exponent negative).
// Invalid operands and modulus one skip the unit and go straight to output with
// a zero result. Otherwise the base is first reduced by the shared modular
// product unit, then right-to-left square-and-multiply runs one product per
// exponent bit set and one square per bit below the top bit; each product scans
// the significant bits of its multiplier. A full 63-bit exponent costs up to 125
// products. The shared shift-add product unit handles one multiplier bit per
// cycle.
// The result sits in an output register; the block goes back to idle and
// takes the next transaction once that register is loaded, so a stalled
// receiver only blocks completion of the following item.
// Reset (synchronous, active low) drops any item in flight and clears the
// output valid.
module modular_exponentiation (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [mexp_pkg::MEXP_W-1:0]  i_base_value,
    input  logic signed [mexp_pkg::MEXP_W-1:0]  i_exponent_value,
    input  logic signed [mexp_pkg::MEXP_W-1:0]  i_modulus_value,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [mexp_pkg::MEXP_RW-1:0]  o_power_result,
    output logic                          o_status
);
    import mexp_pkg::*;

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;  // wait for a transaction
    localparam logic [2:0] S_RED  = 3'd1;  // base reduction in the unit
    localparam logic [2:0] S_EXP  = 3'd2;  // pick next step from exponent
    localparam logic [2:0] S_MUL  = 3'd3;  // acc * b in the unit
    localparam logic [2:0] S_SQR  = 3'd4;  // b * b in the unit
    localparam logic [2:0] S_OUT  = 3'd5;  // hand result to output register

    logic [2:0]         r_state;
    logic [MEXP_RW-1:0] r_acc;
    logic [MEXP_RW-1:0] r_b;
    logic [MEXP_RW-1:0] r_e;
    logic [MEXP_RW-1:0] r_m;
    logic               r_neg;
    logic               r_status;

    t_mm_req            mm_req;
    t_mm_rsp            mm_rsp;

    logic               in_acc;
    logic               bad_op;
    logic               mod_one;
    logic [MEXP_W-1:0]  base_mag;
    logic [MEXP_RW-1:0] red_fix;

    mexp_mulmod u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mm_req),
        .o_rsp   (mm_rsp)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;

    assign bad_op   = i_modulus_value[MEXP_W-1] || (i_modulus_value == '0) ||
                      i_exponent_value[MEXP_W-1];
    assign mod_one  = (i_modulus_value == MEXP_W'(1));
    // magnitude of the base; the most negative value maps to 2^63 exactly
    assign base_mag = i_base_value[MEXP_W-1] ? MEXP_W'(-i_base_value) : i_base_value;
    // a negative base lands at m - r unless r is zero
    assign red_fix  = (r_neg && mm_rsp.result != '0) ? MEXP_RW'(r_m - mm_rsp.result)
                                                      : mm_rsp.result;

    // request to the shared unit: reduce the base as 1 * |base| mod m,
    // then multiply or square as the exponent bits call for
    always_comb begin
        mm_req       = '0;
        mm_req.m     = r_m;
        unique case (r_state)
            S_IDLE: begin
                mm_req.start = in_acc && !bad_op && !mod_one;
                mm_req.x     = MEXP_RW'(1);
                mm_req.y     = base_mag;
                mm_req.m     = i_modulus_value[MEXP_RW-1:0];
            end
            S_EXP: begin
                mm_req.start = (r_e != '0);
                mm_req.x     = r_e[0] ? r_acc : r_b;
                mm_req.y     = {1'b0, r_b};
            end
            S_MUL: begin
                // chain the square right behind the multiply unless it is the last bit
                mm_req.start = mm_rsp.done && (r_e[MEXP_RW-1:1] != '0);
                mm_req.x     = r_b;
                mm_req.y     = {1'b0, r_b};
            end
            S_RED, S_SQR, S_OUT: begin
                mm_req.start = 1'b0;
            end
            default: begin
                mm_req.start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_state <= (bad_op || mod_one) ? S_OUT : S_RED;
                    end
                end
                S_RED: begin
                    if (mm_rsp.done) begin
                        r_state <= S_EXP;
                    end
                end
                S_EXP: begin
                    if (r_e == '0) begin
                        r_state <= S_OUT;
                    end else if (r_e[0]) begin
                        r_state <= S_MUL;
                    end else begin
                        r_state <= S_SQR;
                    end
                end
                S_MUL: begin
                    if (mm_rsp.done) begin
                        r_state <= (r_e[MEXP_RW-1:1] != '0) ? S_SQR : S_EXP;
                    end
                end
                S_SQR: begin
                    if (mm_rsp.done) begin
                        r_state <= S_EXP;
                    end
                end
                S_OUT: begin
                    if (!o_out_valid || i_out_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_acc    <= (bad_op || mod_one) ? '0 : MEXP_RW'(1);
                    r_status <= bad_op ? STATUS_INVALID : STATUS_OK;
                    r_e      <= i_exponent_value[MEXP_RW-1:0];
                    r_m      <= i_modulus_value[MEXP_RW-1:0];
                    r_neg    <= i_base_value[MEXP_W-1];
                end
            end
            S_RED: begin
                if (mm_rsp.done) begin
                    r_b <= red_fix;
                end
            end
            S_MUL: begin
                if (mm_rsp.done) begin
                    r_acc <= mm_rsp.result;
                    if (r_e[MEXP_RW-1:1] == '0) begin
                        r_e <= '0;
                    end
                end
            end
            S_SQR: begin
                if (mm_rsp.done) begin
                    r_b <= mm_rsp.result;
                    r_e <= r_e >> 1;
                end
            end
            S_EXP, S_OUT: begin
                r_neg <= r_neg;
            end
            default: begin
                r_neg <= r_neg;
            end
        endcase
    end

    // output register: hold until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (r_state == S_OUT && (!o_out_valid || i_out_ready)) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && (!o_out_valid || i_out_ready)) begin
            o_power_result <= r_acc;
            o_status       <= r_status;
        end
    end

endmodule

// ===== rtl/core/mexp_checker.sv =====
module mexp_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [mexp_pkg::MEXP_RW-1:0]  o_power_result,
    input logic                          o_status
);
    import mexp_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_power_result) && $stable(o_status))
        else $error("output changed while stalled");

    // an invalid status always carries a zero result
    a_inv_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == STATUS_INVALID) |-> (o_power_result == '0))
        else $error("invalid status with nonzero result");

    // the block is busy in the cycle after taking a transaction
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready right after accept");

    // reset drops the output
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_power_result (o_power_result),
    .o_status       (o_status)
);
